FILE: rtl/bsog_pkg.sv
// ----------------------------------------------------------------------------
// bsog_pkg
// Shared constants and types for the broadcast stride offset generator.
// ----------------------------------------------------------------------------
package bsog_pkg;

  localparam int MAX_RANK       = 4;
  localparam int IDX_BITS       = 32;
  localparam int SIZE_BITS      = 16;
  localparam int STRIDE_BITS    = 32;
  localparam int OFFSET_BITS    = 32;
  localparam int RANK_BITS      = 3;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 64;
  localparam int STEPS_PER_CELL = 4;
  localparam int DIV_CELLS      = IDX_BITS / STEPS_PER_CELL;
  localparam int MAC_STAGES     = 2;
  localparam int LATENCY        = MAX_RANK * (DIV_CELLS + MAC_STAGES);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ACTIVE_RANK   = 3'd0,
    REG_SHAPE_SIZES   = 3'd1,
    REG_STRIDE_A_LOW  = 3'd2,
    REG_STRIDE_A_HIGH = 3'd3,
    REG_STRIDE_B_LOW  = 3'd4,
    REG_STRIDE_B_HIGH = 3'd5
  } bsog_reg_e;

  // item as it moves down the cell chain
  typedef struct packed {
    logic [IDX_BITS-1:0]    idx;    // echo of the flat index
    logic [IDX_BITS-1:0]    quot;   // dividend bits shifting out, quotient shifting in
    logic [SIZE_BITS-1:0]   rem;    // partial remainder, coordinate at end of an axis
    logic [OFFSET_BITS-1:0] off_a;
    logic [OFFSET_BITS-1:0] off_b;
  } bsog_item_t;

endpackage

FILE: rtl/bsog_div_cell.sv
// ----------------------------------------------------------------------------
// bsog_div_cell
// One registered cell of the restoring divider: resolves four quotient bits.
// ----------------------------------------------------------------------------
module bsog_div_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [bsog_pkg::SIZE_BITS-1:0]  divisor_i,
  input  logic                            valid_i,
  input  bsog_pkg::bsog_item_t            item_i,
  output logic                            valid_o,
  output bsog_pkg::bsog_item_t            item_o
);

  logic                 valid_q;
  bsog_pkg::bsog_item_t item_d, item_q;

  always_comb begin
    logic [bsog_pkg::IDX_BITS-1:0]  w;
    logic [bsog_pkg::SIZE_BITS-1:0] r;
    logic [bsog_pkg::SIZE_BITS:0]   t;
    logic                           ge;
    item_d = item_i;
    w      = item_i.quot;
    r      = item_i.rem;
    for (int k = 0; k < bsog_pkg::STEPS_PER_CELL; k++) begin
      t  = {r, w[bsog_pkg::IDX_BITS-1]};
      ge = (t >= {1'b0, divisor_i});
      w  = {w[bsog_pkg::IDX_BITS-2:0], ge};
      // remainder stays below the divisor, so it fits the narrow field
      if (ge) begin
        r = bsog_pkg::SIZE_BITS'(t - {1'b0, divisor_i});
      end else begin
        r = t[bsog_pkg::SIZE_BITS-1:0];
      end
    end
    item_d.quot = w;
    item_d.rem  = r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: rtl/bsog_mac_cell.sv
// ----------------------------------------------------------------------------
// bsog_mac_cell
// Multiplies an axis coordinate by both operand strides and accumulates.
// ----------------------------------------------------------------------------
module bsog_mac_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [bsog_pkg::STRIDE_BITS-1:0] stride_a_i,
  input  logic [bsog_pkg::STRIDE_BITS-1:0] stride_b_i,
  input  logic                             valid_i,
  input  bsog_pkg::bsog_item_t             item_i,
  output logic                             valid_o,
  output bsog_pkg::bsog_item_t             item_o
);

  logic                             mul_valid_q, acc_valid_q;
  bsog_pkg::bsog_item_t             mul_item_q, acc_item_d, acc_item_q;
  logic [bsog_pkg::OFFSET_BITS-1:0] prod_a_d, prod_a_q, prod_b_d, prod_b_q;
  logic [bsog_pkg::OFFSET_BITS-1:0] coord;

  assign coord    = bsog_pkg::OFFSET_BITS'(item_i.rem);
  assign prod_a_d = coord * bsog_pkg::OFFSET_BITS'(stride_a_i);
  assign prod_b_d = coord * bsog_pkg::OFFSET_BITS'(stride_b_i);

  always_comb begin
    acc_item_d       = mul_item_q;
    acc_item_d.off_a = mul_item_q.off_a + prod_a_q;
    acc_item_d.off_b = mul_item_q.off_b + prod_b_q;
    // next axis starts its division with a clear remainder
    acc_item_d.rem   = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      acc_valid_q <= 1'b0;
    end else begin
      mul_valid_q <= valid_i;
      acc_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mul_item_q <= item_i;
    prod_a_q   <= prod_a_d;
    prod_b_q   <= prod_b_d;
    acc_item_q <= acc_item_d;
  end

  assign valid_o = acc_valid_q;
  assign item_o  = acc_item_q;

endmodule

FILE: rtl/broadcast_stride_offset_gen_unit.sv
// ----------------------------------------------------------------------------
// broadcast_stride_offset_gen_unit
// Maps a flat result index to element offsets into two broadcast operands.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start_i with flat_index_i; busy_o stays low, so an item may be
//   given in every clock cycle. Each item comes back exactly once, on
//   result_index_o / offset_a_o / offset_b_o with done_o high for
//   one cycle. Items leave in the order they came in, one per cycle at most.
//   The pipe is four axis passes of ten stages each: eight divider cells that
//   resolve four quotient bits apiece, then a multiply and an accumulate
//   stage. The per-cell 17-bit compare and subtract chain sets the clock.
//   The user writes registers through cfg_we_i / cfg_idx_i / cfg_wdata_i
//   only while no item is in flight (not enforced by the block); writes to
//   unknown indexes are dropped. Reset empties the chain and loads rank 1,
//   every axis size 1 and zero strides. There is no back-pressure: the
//   receiver must take each result in the cycle it is shown.
// ----------------------------------------------------------------------------
module broadcast_stride_offset_gen_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bsog_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [bsog_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i,
  input  logic                               start_i,
  input  logic [bsog_pkg::IDX_BITS-1:0]      flat_index_i,
  output logic                               busy_o,
  output logic                               done_o,
  output logic [bsog_pkg::IDX_BITS-1:0]      result_index_o,
  output logic [bsog_pkg::OFFSET_BITS-1:0]   offset_a_o,
  output logic [bsog_pkg::OFFSET_BITS-1:0]   offset_b_o
);

  logic [bsog_pkg::RANK_BITS-1:0]     active_rank_q;
  logic [bsog_pkg::CFG_DATA_BITS-1:0] shape_sizes_q;
  logic [bsog_pkg::CFG_DATA_BITS-1:0] stride_a_low_q, stride_a_high_q;
  logic [bsog_pkg::CFG_DATA_BITS-1:0] stride_b_low_q, stride_b_high_q;
  logic [bsog_pkg::RANK_BITS-1:0]     rank_eff;
  logic [2*bsog_pkg::CFG_DATA_BITS-1:0] stride_a_all, stride_b_all;

  logic                 pass_v    [bsog_pkg::MAX_RANK+1];
  bsog_pkg::bsog_item_t pass_item [bsog_pkg::MAX_RANK+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_rank_q   <= bsog_pkg::RANK_BITS'(1);
      shape_sizes_q   <= 64'h0001_0001_0001_0001;
      stride_a_low_q  <= '0;
      stride_a_high_q <= '0;
      stride_b_low_q  <= '0;
      stride_b_high_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bsog_pkg::REG_ACTIVE_RANK:   active_rank_q   <= cfg_wdata_i[bsog_pkg::RANK_BITS-1:0];
        bsog_pkg::REG_SHAPE_SIZES:   shape_sizes_q   <= cfg_wdata_i;
        bsog_pkg::REG_STRIDE_A_LOW:  stride_a_low_q  <= cfg_wdata_i;
        bsog_pkg::REG_STRIDE_A_HIGH: stride_a_high_q <= cfg_wdata_i;
        bsog_pkg::REG_STRIDE_B_LOW:  stride_b_low_q  <= cfg_wdata_i;
        bsog_pkg::REG_STRIDE_B_HIGH: stride_b_high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign rank_eff = (active_rank_q > bsog_pkg::RANK_BITS'(bsog_pkg::MAX_RANK))
                  ? bsog_pkg::RANK_BITS'(bsog_pkg::MAX_RANK) : active_rank_q;
  assign stride_a_all = {stride_a_high_q, stride_a_low_q};
  assign stride_b_all = {stride_b_high_q, stride_b_low_q};

  assign pass_v[0]    = start_i;
  assign pass_item[0] = '{idx: flat_index_i, quot: flat_index_i, rem: '0,
                          off_a: '0, off_b: '0};

  // innermost axis is peeled off first; inactive axes divide by one
  for (genvar p = 0; p < bsog_pkg::MAX_RANK; p++) begin : g_pass
    localparam int AX = bsog_pkg::MAX_RANK - 1 - p;

    logic [bsog_pkg::SIZE_BITS-1:0] raw_size, divisor;
    logic                           dv [bsog_pkg::DIV_CELLS+1];
    bsog_pkg::bsog_item_t           di [bsog_pkg::DIV_CELLS+1];

    assign raw_size = shape_sizes_q[AX*bsog_pkg::SIZE_BITS +: bsog_pkg::SIZE_BITS];
    assign divisor  = (bsog_pkg::RANK_BITS'(AX) < rank_eff && raw_size != '0)
                    ? raw_size : bsog_pkg::SIZE_BITS'(1);
    assign dv[0] = pass_v[p];
    assign di[0] = pass_item[p];

    for (genvar c = 0; c < bsog_pkg::DIV_CELLS; c++) begin : g_div
      bsog_div_cell u_div (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .divisor_i (divisor),
        .valid_i   (dv[c]),
        .item_i    (di[c]),
        .valid_o   (dv[c+1]),
        .item_o    (di[c+1])
      );
    end

    bsog_mac_cell u_mac (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .stride_a_i (stride_a_all[AX*bsog_pkg::STRIDE_BITS +: bsog_pkg::STRIDE_BITS]),
      .stride_b_i (stride_b_all[AX*bsog_pkg::STRIDE_BITS +: bsog_pkg::STRIDE_BITS]),
      .valid_i    (dv[bsog_pkg::DIV_CELLS]),
      .item_i     (di[bsog_pkg::DIV_CELLS]),
      .valid_o    (pass_v[p+1]),
      .item_o     (pass_item[p+1])
    );
  end

  assign busy_o         = 1'b0;
  assign done_o         = pass_v[bsog_pkg::MAX_RANK];
  assign result_index_o = pass_item[bsog_pkg::MAX_RANK].idx;
  assign offset_a_o     = pass_item[bsog_pkg::MAX_RANK].off_a;
  assign offset_b_o     = pass_item[bsog_pkg::MAX_RANK].off_b;

endmodule

FILE: dv/tb_broadcast_stride_offset_gen_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_broadcast_stride_offset_gen_unit
// Checks the flat-index to operand-offset mapping of the broadcast stride
// offset generator. A scoreboard predicts the index and both offsets of
// every accepted index from its own copy of the registers, and compares each
// done strobe against the oldest prediction. Directed settings cover rank 0,
// saturated rank, zero shape entries, wrap past the tensor end and offset
// overflow; random settings with random sender gaps follow.
// ----------------------------------------------------------------------------
module tb_broadcast_stride_offset_gen_unit;

  localparam int CLK_PERIOD    = 20;
  localparam int RANDOM_ITEMS  = 550;
  localparam int QUIET_TAIL    = 80;
  localparam int PRESSURE_AT   = 137;
  localparam int CYCLE_LIMIT   = 200000;

  // register indexes that the block does not decode
  localparam logic [bsog_pkg::CFG_IDX_BITS-1:0] CFG_IDX_SPARE_LO = 3'd6;
  localparam logic [bsog_pkg::CFG_IDX_BITS-1:0] CFG_IDX_SPARE_HI = 3'd7;

  typedef struct {
    logic [bsog_pkg::IDX_BITS-1:0]    idx;
    logic [bsog_pkg::OFFSET_BITS-1:0] off_a;
    logic [bsog_pkg::OFFSET_BITS-1:0] off_b;
  } offset_set_t;

  class stride_offset_board;
    logic [bsog_pkg::RANK_BITS-1:0]   rank = 3'd1;
    logic [63:0]                      shape = 64'h0001_0001_0001_0001;
    logic [bsog_pkg::STRIDE_BITS-1:0] stride_a [4] = '{default: '0};
    logic [bsog_pkg::STRIDE_BITS-1:0] stride_b [4] = '{default: '0};
    offset_set_t                      expected_offsets [$];
    int                               mismatches = 0;

    task report_mismatch(string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      mismatches++;
    endtask

    function void note_register(logic [bsog_pkg::CFG_IDX_BITS-1:0] idx, logic [63:0] data);
      case (idx)
        bsog_pkg::REG_ACTIVE_RANK:   rank = data[bsog_pkg::RANK_BITS-1:0];
        bsog_pkg::REG_SHAPE_SIZES:   shape = data;
        bsog_pkg::REG_STRIDE_A_LOW:  begin stride_a[0] = data[31:0]; stride_a[1] = data[63:32]; end
        bsog_pkg::REG_STRIDE_A_HIGH: begin stride_a[2] = data[31:0]; stride_a[3] = data[63:32]; end
        bsog_pkg::REG_STRIDE_B_LOW:  begin stride_b[0] = data[31:0]; stride_b[1] = data[63:32]; end
        bsog_pkg::REG_STRIDE_B_HIGH: begin stride_b[2] = data[31:0]; stride_b[3] = data[63:32]; end
        default: ;
      endcase
    endfunction

    function int axes_used();
      return (int'(rank) > bsog_pkg::MAX_RANK) ? bsog_pkg::MAX_RANK : int'(rank);
    endfunction

    function logic [31:0] axis_size(int ax);
      logic [15:0] s;
      s = shape[ax*16 +: 16];
      return (s == 16'd0) ? 32'd1 : 32'(s);
    endfunction

    // number of elements spanned by the active axes
    function logic [63:0] tensor_elements();
      logic [63:0] prod;
      prod = 64'd1;
      for (int ax = 0; ax < axes_used(); ax++) prod = prod * 64'(axis_size(ax));
      return prod;
    endfunction

    // innermost active axis is peeled off first; offsets wrap at 32 bits
    function offset_set_t map_offsets(logic [bsog_pkg::IDX_BITS-1:0] flat);
      offset_set_t res;
      logic [31:0] rest;
      logic [31:0] coord;
      res.idx = flat;
      res.off_a = '0;
      res.off_b = '0;
      rest = flat;
      for (int ax = axes_used() - 1; ax >= 0; ax--) begin
        coord = rest % axis_size(ax);
        rest = rest / axis_size(ax);
        res.off_a = res.off_a + coord * stride_a[ax];
        res.off_b = res.off_b + coord * stride_b[ax];
      end
      return res;
    endfunction

    function void note_item(logic [bsog_pkg::IDX_BITS-1:0] flat);
      expected_offsets.push_back(map_offsets(flat));
    endfunction

    task check_result(logic [bsog_pkg::IDX_BITS-1:0] idx,
                      logic [bsog_pkg::OFFSET_BITS-1:0] oa,
                      logic [bsog_pkg::OFFSET_BITS-1:0] ob);
      offset_set_t exp_set;
      if (expected_offsets.size() == 0) begin
        report_mismatch($sformatf("result idx %h with no item outstanding", idx));
      end else begin
        exp_set = expected_offsets.pop_front();
        if (idx !== exp_set.idx)
          report_mismatch($sformatf("result_index %h, want %h", idx, exp_set.idx));
        if (oa !== exp_set.off_a)
          report_mismatch($sformatf("idx %h offset_a %h, want %h", exp_set.idx, oa,
                                    exp_set.off_a));
        if (ob !== exp_set.off_b)
          report_mismatch($sformatf("idx %h offset_b %h, want %h", exp_set.idx, ob,
                                    exp_set.off_b));
      end
    endtask

    function int pending();
      return expected_offsets.size();
    endfunction

    task flush_leftovers();
      offset_set_t left;
      while (expected_offsets.size() != 0) begin
        left = expected_offsets.pop_front();
        report_mismatch($sformatf("no result for idx %h", left.idx));
      end
    endtask
  endclass

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               cfg_we_i = 1'b0;
  logic [bsog_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i = '0;
  logic [bsog_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i = '0;
  logic                               start_i = 1'b0;
  logic [bsog_pkg::IDX_BITS-1:0]      flat_index_i = '0;
  logic                               busy_o;
  logic                               done_o;
  logic [bsog_pkg::IDX_BITS-1:0]      result_index_o;
  logic [bsog_pkg::OFFSET_BITS-1:0]   offset_a_o;
  logic [bsog_pkg::OFFSET_BITS-1:0]   offset_b_o;

  stride_offset_board board;
  int unsigned        cycles = 0;

  broadcast_stride_offset_gen_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start_i        (start_i),
    .flat_index_i   (flat_index_i),
    .busy_o         (busy_o),
    .done_o         (done_o),
    .result_index_o (result_index_o),
    .offset_a_o     (offset_a_o),
    .offset_b_o     (offset_b_o)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && board != null) begin
      if (start_i && !busy_o) board.note_item(flat_index_i);
      if (done_o) board.check_result(result_index_o, offset_a_o, offset_b_o);
    end
  end

  // holds start high until the item is taken; the caller lowers it
  task send_item(logic [bsog_pkg::IDX_BITS-1:0] flat);
    start_i      <= 1'b1;
    flat_index_i <= flat;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
  endtask

  task pause(int n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // keeps the write enable high; apply_setting lowers it
  task write_reg(logic [bsog_pkg::CFG_IDX_BITS-1:0] idx, logic [63:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    board.note_register(idx, data);
  endtask

  task apply_setting(logic [63:0] rank_word, logic [63:0] shape, logic [63:0] a_lo,
                     logic [63:0] a_hi, logic [63:0] b_lo, logic [63:0] b_hi);
    write_reg(bsog_pkg::REG_ACTIVE_RANK, rank_word);
    write_reg(bsog_pkg::REG_SHAPE_SIZES, shape);
    write_reg(bsog_pkg::REG_STRIDE_A_LOW, a_lo);
    write_reg(bsog_pkg::REG_STRIDE_A_HIGH, a_hi);
    write_reg(bsog_pkg::REG_STRIDE_B_LOW, b_lo);
    write_reg(bsog_pkg::REG_STRIDE_B_HIGH, b_hi);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function logic [31:0] rand_stride();
    case ($urandom_range(0, 9))
      0, 1:    return 32'd0;
      2, 3, 4: return 32'($urandom_range(1, 64));
      5:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function logic [15:0] rand_axis();
    case ($urandom_range(0, 9))
      0:             return 16'd0;
      1, 2, 3, 4, 5: return 16'($urandom_range(1, 6));
      6:             return 16'hFFFF;
      default:       return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task randomize_setting();
    logic [2:0]  rank;
    logic [63:0] rank_word;
    logic [63:0] shape;
    case ($urandom_range(0, 9))
      0:       rank = 3'd0;
      1:       rank = 3'($urandom_range(5, 7));
      default: rank = 3'($urandom_range(1, 4));
    endcase
    // upper bits of the rank word are don't-care
    rank_word = {$urandom, $urandom};
    rank_word[2:0] = rank;
    shape = {rand_axis(), rand_axis(), rand_axis(), rand_axis()};
    apply_setting(rank_word, shape,
                  {rand_stride(), rand_stride()}, {rand_stride(), rand_stride()},
                  {rand_stride(), rand_stride()}, {rand_stride(), rand_stride()});
  endtask

  function logic [bsog_pkg::IDX_BITS-1:0] pick_index();
    logic [63:0] span;
    span = board.tensor_elements();
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6: return $urandom;
      7, 8: begin
        // around the tensor end, including a wrap onto the start
        if (span > 64'hFFFF_FFFF) return 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
        return 32'(span) + 32'($urandom_range(0, 2)) - 32'd1;
      end
      9:  return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
      10: return 32'd1 << $urandom_range(0, 31);
      default: begin
        if (span > 64'hFFFF_FFFF) return $urandom;
        return 32'($urandom_range(0, 32'(span - 64'd1)));
      end
    endcase
  endfunction

  initial begin
    int  total;
    int  phase_len;
    bit  gappy;
    board = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting: one axis of size one, zero strides
    send_item(32'd0);
    send_item(32'hFFFF_FFFF);
    drain();

    // widest shape, all-ones strides on A, distinct small strides on B
    apply_setting(64'd4, 64'hFFFF_FFFF_FFFF_FFFF,
                  64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                  64'h0000_0010_0000_0001, 64'h0000_1000_0000_0100);
    send_item(32'd0);
    send_item(32'hFFFF_FFFF);
    send_item(32'h8000_0000);
    send_item(32'h0000_FFFE);
    send_item(32'h1234_5678);
    drain();

    // zero shape entries collapse their axis; zero strides broadcast
    apply_setting(64'd4, 64'h0005_0000_0003_0000,
                  64'h0000_0001_0000_0000, 64'h0000_0000_0000_0007,
                  64'h0000_0000_0000_0001, 64'h0000_0002_0000_0000);
    send_item(32'd0);
    send_item(32'd14);
    send_item(32'd15);
    send_item(32'hFFFF_FFFF);
    drain();

    // no active axis
    apply_setting(64'hFFFF_FFFF_FFFF_FFF8, 64'h0007_0006_0005_0004,
                  64'h0000_0003_0000_0002, 64'h0000_0005_0000_0004,
                  64'h0000_0009_0000_0008, 64'h0000_000B_0000_000A);
    send_item(32'd7);
    send_item(32'hFFFF_FFFF);
    drain();

    // rank past the limit saturates; undecoded indexes are dropped
    write_reg(CFG_IDX_SPARE_LO, 64'hDEAD_BEEF_0BAD_F00D);
    write_reg(CFG_IDX_SPARE_HI, 64'hFFFF_FFFF_FFFF_FFFF);
    apply_setting(64'd7, 64'h0005_0004_0003_0002,
                  64'h0000_0002_0000_0001, 64'h0000_0008_0000_0004,
                  64'h0000_003C_0000_0001, 64'h0000_0001_0000_0014);
    send_item(32'd0);
    send_item(32'd119);
    send_item(32'd120);
    send_item(32'd1000);
    drain();

    // two full axes with strides large enough to overflow
    apply_setting(64'd2, 64'h0001_0001_FFFF_FFFF,
                  64'hF000_0001_8000_0003, 64'd0,
                  64'hFFFF_FFFF_0001_0000, 64'd0);
    send_item(32'hFFFF_FFFF);
    send_item(32'hFFFE_FFFF);
    drain();

    total = 0;
    while (total < RANDOM_ITEMS) begin
      randomize_setting();
      phase_len = $urandom_range(25, 70);
      gappy = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < phase_len && total < RANDOM_ITEMS; n++) begin
        if (total == PRESSURE_AT) drain();
        if (gappy && total < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 3) == 0)
          pause($urandom_range(1, 13));
        send_item(pick_index());
        total++;
      end
      drain();
    end

    repeat (bsog_pkg::LATENCY + 10) @(posedge clk_i);
    board.flush_leftovers();
    if (board.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/bsog_pkg.sv
rtl/bsog_div_cell.sv
rtl/bsog_mac_cell.sv
rtl/broadcast_stride_offset_gen_unit.sv
dv/tb_broadcast_stride_offset_gen_unit.sv
